[src/tccs_pkg.sv]
// Shared constants for the text console with cursor and scroll.
// Holds the default screen geometry, field widths and control character codes.
// No dependencies.
package tccs_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int RCOL_W = 7;
  localparam int RROW_W = 5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CODE_W-1:0] CH_BLANK = 8'h20;
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;

  localparam logic REQ_PRINT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

endpackage

[src/text_console_cursor_scroll_core.sv]
// Top level of the text console with cursor and scroll.
// Depends on tccs_pkg and on tccs_ram for the screen memory.
//
// Channel   Direction  Contents
// s_axis    in         tuser: req_type; tdata: char_code, read_col, read_row
// m_axis    out        tdata: cursor_col, cursor_row, cell_value
// cfg       in         text_attr, written when cfg_we is high
//
// A print runs EXEC then RESP; a read runs RD, EXEC, RESP through the screen RAM port.
// A backspace that moves the cursor adds the S_BSW state for its blanking write.
// A tab blanks up to 8 cells in the S_TAB state, one write per cell.
// A scroll blanks the COLS cells of the recycled row; rows are addressed through a top pointer.
// After reset a clearing pass writes zero to all COLS*ROWS cells before any transaction.
// One finished result can wait at the output while the next transaction is accepted.
module text_console_cursor_scroll_core
  import tccs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // char_code [7:0], read_col [14:8], read_row [19:15], zero [23:20]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cursor_col [6:0], cursor_row [11:7], cell_value [27:12], zero [31:28]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [ATTR_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = COLS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_BSW    = 3'd3;
  localparam logic [2:0] S_TAB    = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_RD     = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  logic [2:0]          state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [COL_W-1:0]    scr_cnt;
  logic [ROW_W-1:0]    top;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [ATTR_W-1:0]   text_attr;
  logic                tab_pend;
  logic                req_type;
  logic [CODE_W-1:0]   char_code;
  logic [RCOL_W-1:0]   read_col;
  logic [RROW_W-1:0]   read_row;
  logic                rd_ok;
  logic [CELL_W-1:0]   rd_cell;

  logic                out_valid;
  logic [RCOL_W-1:0]   out_col;
  logic [RROW_W-1:0]   out_row;
  logic [CELL_W-1:0]   out_cell;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [CELL_W-1:0]   mem_rdata;
  logic [CELL_W-1:0]   blank;
  logic [COL_W:0]      col_inc;
  logic                printable;
  logic [COL_W-1:0]    rd_col_idx;
  logic [ROW_W-1:0]    rd_row_idx;
  logic                load_out;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] sum;
    logic [ROW_W:0] phys;
    sum  = {1'b0, base} + {1'b0, row};
    phys = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
    return ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  assign blank      = {text_attr, CH_BLANK};
  assign col_inc    = {1'b0, cur_col} + 1'b1;
  assign printable  = (char_code != CH_BS) && (char_code != CH_TAB) &&
                      (char_code != CH_CR) && (char_code != CH_LF);
  assign rd_col_idx = rd_ok ? COL_W'(read_col) : '0;
  assign rd_row_idx = rd_ok ? ROW_W'(read_row) : '0;

  assign s_axis_tready = (state == S_IDLE);
  assign load_out      = (state == S_RESP) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_cell, out_row, out_col};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = blank;
    mem_addr  = cell_addr(top, cur_row, cur_col);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = clr_cnt;
      end
      S_SCROLL: begin
        mem_we   = 1'b1;
        mem_addr = cell_addr(top, '0, scr_cnt);
      end
      S_RD: begin
        mem_addr = cell_addr(top, rd_row_idx, rd_col_idx);
      end
      S_EXEC: begin
        mem_we    = (req_type == REQ_PRINT) && printable;
        mem_wdata = {text_attr, char_code};
      end
      S_BSW, S_TAB: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tccs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (cfg_we) begin
      text_attr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_type  <= s_axis_tuser;
      char_code <= s_axis_tdata[7:0];
      read_col  <= s_axis_tdata[14:8];
      read_row  <= s_axis_tdata[19:15];
      rd_ok     <= (32'(s_axis_tdata[14:8]) < 32'(COLS)) &&
                   (32'(s_axis_tdata[19:15]) < 32'(ROWS));
      rd_cell   <= '0;
    end else if (state == S_RD) begin
      rd_cell <= '0;
    end else if (state == S_RESP && req_type == REQ_READ && !load_out) begin
      rd_cell <= rd_cell;
    end
    if (state == S_EXEC && req_type == REQ_READ) begin
      rd_cell <= rd_ok ? mem_rdata : '0;
    end
    if (load_out) begin
      out_col  <= RCOL_W'(cur_col);
      out_row  <= RROW_W'(cur_row);
      out_cell <= rd_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      scr_cnt   <= '0;
      top       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      tab_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= (s_axis_tuser == REQ_READ) ? S_RD : S_EXEC;
          end
        end
        S_RD: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state   <= S_RESP;
          scr_cnt <= '0;
          if (req_type == REQ_PRINT) begin
            case (char_code)
              CH_BS: begin
                if (cur_col == '0 && cur_row == '0) begin
                  state <= S_RESP;
                end else if (cur_col == '0) begin
                  cur_col <= COL_LAST;
                  cur_row <= cur_row - 1'b1;
                  state   <= S_BSW;
                end else begin
                  cur_col <= cur_col - 1'b1;
                  state   <= S_BSW;
                end
              end
              CH_TAB: begin
                state <= S_TAB;
                if (cur_col == COL_LAST) begin
                  cur_col <= '0;
                  if (cur_row == ROW_LAST) begin
                    tab_pend <= 1'b1;
                    state    <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end
              end
              CH_CR: begin
                cur_col <= '0;
              end
              CH_LF: begin
                cur_col <= '0;
                if (cur_row == ROW_LAST) begin
                  tab_pend <= 1'b0;
                  state    <= S_SCROLL;
                end else begin
                  cur_row <= cur_row + 1'b1;
                end
              end
              default: begin
                if (col_inc == (COL_W+1)'(COLS)) begin
                  cur_col <= '0;
                  if (cur_row == ROW_LAST) begin
                    tab_pend <= 1'b0;
                    state    <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else begin
                  cur_col <= COL_W'(col_inc);
                end
              end
            endcase
          end
        end
        S_BSW: begin
          state <= S_RESP;
        end
        S_TAB: begin
          scr_cnt <= '0;
          if (col_inc == (COL_W+1)'(COLS)) begin
            cur_col <= '0;
            if (cur_row == ROW_LAST) begin
              tab_pend <= 1'b0;
              state    <= S_SCROLL;
            end else begin
              cur_row <= cur_row + 1'b1;
              state   <= S_RESP;
            end
          end else begin
            cur_col <= COL_W'(col_inc);
            if (col_inc[2:0] == 3'd0) begin
              state <= S_RESP;
            end
          end
        end
        S_SCROLL: begin
          scr_cnt <= scr_cnt + 1'b1;
          if (scr_cnt == COL_LAST) begin
            top      <= (top == ROW_LAST) ? '0 : top + 1'b1;
            tab_pend <= 1'b0;
            state    <= tab_pend ? S_TAB : S_RESP;
          end
        end
        S_RESP: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/tccs_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// Holds the screen cells of the console; no dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for text_console_cursor_scroll_core.
// Drives print and read transactions, predicts cursor and cell contents in a behavioral
// screen model and checks every result; depends on tccs_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tccs_pkg::*;

  // Fields from the lowest bit up: cursor_col, cursor_row, cell_value.
  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic [RROW_W-1:0] row;
    logic [RCOL_W-1:0] col;
  } console_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = REQ_PRINT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [ATTR_W-1:0]     cfg_wdata = '0;

  logic                  steady = 1'b0;
  int unsigned           mismatches = 0;

  logic [CELL_W-1:0]     scr [ROWS_DEF][COLS_DEF];
  int unsigned           csr_col = 0;
  int unsigned           csr_row = 0;
  logic [ATTR_W-1:0]     attr_now = ATTR_RESET;
  console_result_t       expected_cursor_cell [$];

  text_console_cursor_scroll_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_now, CH_BLANK};
  endfunction

  function automatic void scroll_if_past_bottom();
    if (csr_row >= ROWS_DEF) begin
      for (int r = 0; r < ROWS_DEF - 1; r++) begin
        for (int c = 0; c < COLS_DEF; c++) begin
          scr[r][c] = scr[r + 1][c];
        end
      end
      for (int c = 0; c < COLS_DEF; c++) begin
        scr[ROWS_DEF - 1][c] = blank_cell();
      end
      csr_row = ROWS_DEF - 1;
    end
  endfunction

  function automatic console_result_t console_apply(input logic req,
                                                    input logic [CODE_W-1:0] code,
                                                    input logic [RCOL_W-1:0] rcol,
                                                    input logic [RROW_W-1:0] rrow);
    console_result_t res;
    int unsigned     stop;
    res = '0;
    if (req == REQ_PRINT) begin
      if (code == CH_BS) begin
        if (csr_col != 0 || csr_row != 0) begin
          if (csr_col == 0) begin
            csr_col = COLS_DEF - 1;
            csr_row--;
          end else begin
            csr_col--;
          end
          scr[csr_row][csr_col] = blank_cell();
        end
      end else if (code == CH_TAB) begin
        if (csr_col >= COLS_DEF - 1) begin
          csr_col = 0;
          csr_row++;
          scroll_if_past_bottom();
        end
        stop = (csr_col / 8) * 8 + 8;
        while (csr_col < stop && csr_col < COLS_DEF) begin
          scr[csr_row][csr_col] = blank_cell();
          csr_col++;
        end
        if (csr_col >= COLS_DEF) begin
          csr_col = 0;
          csr_row++;
        end
      end else if (code == CH_CR) begin
        csr_col = 0;
      end else if (code == CH_LF) begin
        csr_col = 0;
        csr_row++;
      end else begin
        scr[csr_row][csr_col] = {attr_now, code};
        csr_col++;
        if (csr_col >= COLS_DEF) begin
          csr_col = 0;
          csr_row++;
        end
      end
      scroll_if_past_bottom();
    end else if (rcol < COLS_DEF && rrow < ROWS_DEF) begin
      res.value = scr[rrow][rcol];
    end
    res.col = csr_col[RCOL_W-1:0];
    res.row = csr_row[RROW_W-1:0];
    return res;
  endfunction

  task automatic send_item(input logic req, input logic [CODE_W-1:0] code,
                           input logic [RCOL_W-1:0] rcol, input logic [RROW_W-1:0] rrow);
    while (!steady && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(IN_DATA_W - CODE_W - RCOL_W - RROW_W){1'b0}}, rrow, rcol, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_cursor_cell.push_back(console_apply(req, code, rcol, rrow));
  endtask

  task automatic print_char(input logic [CODE_W-1:0] code);
    send_item(REQ_PRINT, code, RCOL_W'($urandom_range(127)), RROW_W'($urandom_range(31)));
  endtask

  task automatic read_cell(input int unsigned rcol, input int unsigned rrow);
    send_item(REQ_READ, CODE_W'($urandom_range(255)), RCOL_W'(rcol), RROW_W'(rrow));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_cursor_cell.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    attr_now = value;
  endtask

  task automatic test_reset_reads();
    read_cell(0, 0);
    read_cell(COLS_DEF - 1, ROWS_DEF - 1);
    read_cell(127, 31);
    read_cell(COLS_DEF, 3);
    read_cell(5, ROWS_DEF);
  endtask

  task automatic test_cursor_controls();
    print_char(CH_BS);
    print_char(8'h00);
    print_char(8'hFF);
    print_char(8'h07);
    print_char(CH_BS);
    read_cell(2, 0);
    print_char(CH_CR);
    print_char(CH_LF);
    print_char(CH_BS);
    print_char(CH_TAB);
    print_char(CH_TAB);
    read_cell(0, 0);
    read_cell(15, 1);
  endtask

  task automatic test_attr_extremes();
    write_attr(8'h00);
    print_char(8'h41);
    read_cell(csr_col - 1, csr_row);
    write_attr(8'hFF);
    print_char(8'h7E);
    print_char(CH_BS);
    read_cell(csr_col, csr_row);
  endtask

  // Walks the cursor to the last row, parks it on the last column with tabs and
  // text, then tabs and feeds a line so that the screen scrolls.
  task automatic test_scroll_wrap();
    write_attr(ATTR_W'($urandom_range(255)));
    print_char(CH_CR);
    while (csr_row < ROWS_DEF - 1) print_char(CH_LF);
    repeat (9) print_char(CH_TAB);
    repeat (7) print_char(CODE_W'($urandom_range(8'h7E, 8'h21)));
    print_char(CH_TAB);
    read_cell(COLS_DEF - 8, ROWS_DEF - 2);
    read_cell(0, ROWS_DEF - 1);
    print_char(CH_LF);
    read_cell(COLS_DEF - 2, ROWS_DEF - 3);
    read_cell(COLS_DEF - 1, ROWS_DEF - 1);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      read_cell($urandom_range(127), $urandom_range(31));
    end else if (pick < 15) begin
      read_cell($urandom_range(COLS_DEF - 1),
                $urandom_range(1) ? csr_row : $urandom_range(ROWS_DEF - 1));
    end else if (pick < 23) begin
      print_char(CH_BS);
    end else if (pick < 31) begin
      print_char(CH_TAB);
    end else if (pick < 37) begin
      print_char(CH_CR);
    end else if (pick < 47) begin
      print_char(CH_LF);
    end else begin
      print_char(CODE_W'($urandom_range(255)));
    end
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < 4; phase++) begin
      write_attr(ATTR_W'($urandom_range(255)));
      steady <= (phase == 2);
      for (int n = 0; n < 125; n++) send_random_item();
    end
    steady <= 1'b0;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    console_result_t want;
    console_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = console_result_t'(m_axis_tdata[CELL_W+RROW_W+RCOL_W-1:0]);
      if (expected_cursor_cell.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_cursor_cell.pop_front();
        if (got.col !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, got.col);
          mismatches++;
        end
        if (got.row !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, got.row);
          mismatches++;
        end
        if (got.value !== want.value) begin
          $error("cell_value: expected %h, got %h", want.value, got.value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < ROWS_DEF; r++) begin
      for (int c = 0; c < COLS_DEF; c++) begin
        scr[r][c] = '0;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_reads();
    test_cursor_controls();
    test_attr_extremes();
    test_scroll_wrap();
    test_random_text();
    wait_drained();
    if (mismatches == 0) begin
      $display("text_console_cursor_scroll_core regression: pass");
    end else begin
      $display("text_console_cursor_scroll_core regression: fail");
    end
    $finish;
  end

  initial begin
    #7_200_000;
    $display("text_console_cursor_scroll_core regression: fail");
    $finish;
  end

endmodule
